>>> design/source_keyword_loop_io_scanner_macros.svh
// assertion macros for the keyword scanner
`ifndef SOURCE_KEYWORD_LOOP_IO_SCANNER_MACROS_SVH
`define SOURCE_KEYWORD_LOOP_IO_SCANNER_MACROS_SVH

// same-cycle implication
`define SKL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scanner assertion failed");

// next-cycle implication
`define SKL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scanner assertion failed");

`endif

>>> design/skl_pkg.sv
// types, constants and helpers shared by the keyword scanner
`default_nettype none
package skl_pkg;

  typedef enum logic [1:0] {
    LEX_CODE    = 2'd0,
    LEX_STRING  = 2'd1,
    LEX_ESCAPE  = 2'd2,
    LEX_COMMENT = 2'd3
  } lex_mode_e;

  localparam int unsigned WinBytes = 6;
  localparam int unsigned WinFlags = 5;
  localparam int unsigned NumKw    = 5;
  localparam int unsigned KwMaxLen = 6;

  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChHash      = 8'h23;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChNewline   = 8'h0a;

  typedef struct packed {
    logic [WinBytes-1:0][7:0] bytes;
    logic [WinFlags-1:0]      code;
    logic [2:0]               count;
  } win_t;

  localparam logic [7:0] KwText [NumKw][KwMaxLen] = '{
    '{8'h66, 8'h6f, 8'h72, 8'h20, 8'h00, 8'h00},
    '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h20},
    '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h28},
    '{8'h69, 8'h6e, 8'h70, 8'h75, 8'h74, 8'h28},
    '{8'h6f, 8'h70, 8'h65, 8'h6e, 8'h28, 8'h00}
  };
  localparam logic [2:0] KwLen [NumKw] = '{3'd4, 3'd6, 3'd6, 3'd6, 3'd5};
  localparam logic KwIsLoop [NumKw] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
           (c >= 8'h61 && c <= 8'h7a);
  endfunction

endpackage
`default_nettype wire

>>> design/skl_lexer.sv
// lexer mode machine and recent byte window
`default_nettype none
module skl_lexer import skl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic       clr_i,
  input  wire logic [7:0] char_i,
  output logic            as_code_o,
  output win_t            win_o
);

  lex_mode_e mode_q, mode_d;
  logic      single_q, single_d;
  win_t      win_q, win_d;

  // next state
  always_comb begin
    mode_d   = mode_q;
    single_d = single_q;
    if (step_i) begin
      case (mode_q)
        LEX_CODE: begin
          if (char_i == ChDquote || char_i == ChSquote) begin
            mode_d   = LEX_STRING;
            single_d = (char_i == ChSquote);
          end else if (char_i == ChHash) begin
            mode_d = LEX_COMMENT;
          end
        end
        LEX_STRING: begin
          if (char_i == ChBackslash) begin
            mode_d = LEX_ESCAPE;
          end else if (char_i == (single_q ? ChSquote : ChDquote)) begin
            mode_d = LEX_CODE;
          end
        end
        LEX_ESCAPE: mode_d = LEX_STRING;
        LEX_COMMENT: begin
          if (char_i == ChNewline) begin
            mode_d = LEX_CODE;
          end
        end
        default: mode_d = LEX_CODE;
      endcase
    end
    if (clr_i) begin
      mode_d   = LEX_CODE;
      single_d = 1'b0;
    end
  end

  // outputs
  always_comb begin
    as_code_o = (mode_q == LEX_CODE);
    win_o     = win_q;
  end

  always_comb begin
    win_d = win_q;
    if (step_i) begin
      win_d.bytes = {win_q.bytes[WinBytes-2:0], char_i};
      win_d.code  = {win_q.code[WinFlags-2:0], as_code_o};
      win_d.count = (win_q.count == 3'd7) ? 3'd7 : win_q.count + 3'd1;
    end
    if (clr_i) begin
      win_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= LEX_CODE;
      single_q <= 1'b0;
      win_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      single_q <= single_d;
      win_q    <= win_d;
    end
  end

endmodule
`default_nettype wire

>>> design/skl_match.sv
// keyword compare over the window including the incoming byte
`default_nettype none
module skl_match import skl_pkg::*; (
  input  wire logic       step_i,
  input  wire logic [7:0] char_i,
  input  wire logic       as_code_i,
  input  win_t            win_i,
  output logic            loop_hit_o,
  output logic            io_hit_o
);

  logic [WinBytes:0][7:0] nb;
  logic [WinFlags:0]      nf;
  logic [2:0]             cnt;
  logic                   hit;
  logic [2:0]             idx;

  always_comb begin
    nb  = {win_i.bytes, char_i};
    nf  = {win_i.code, as_code_i};
    cnt = (win_i.count == 3'd7) ? 3'd7 : win_i.count + 3'd1;
    loop_hit_o = 1'b0;
    io_hit_o   = 1'b0;
    hit = 1'b0;
    idx = '0;
    for (int w = 0; w < NumKw; w++) begin
      hit = step_i && (cnt >= KwLen[w]);
      for (int j = 0; j < KwMaxLen; j++) begin
        if (3'(j) < KwLen[w]) begin
          idx = KwLen[w] - 3'd1 - 3'(j);
          if (nb[idx] != KwText[w][j]) begin
            hit = 1'b0;
          end
        end
      end
      if (!nf[KwLen[w] - 3'd1]) begin
        hit = 1'b0;
      end
      if (cnt > KwLen[w] && is_alnum(nb[KwLen[w]])) begin
        hit = 1'b0;
      end
      if (hit) begin
        if (KwIsLoop[w]) begin
          loop_hit_o = 1'b1;
        end else begin
          io_hit_o = 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/source_keyword_loop_io_scanner.sv
// top level of the script keyword scanner
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | char_code, has_char, end_of_body
//   out     | output    | out_valid_o / out_stall_i | loop_found, io_found, jittable
//
// one request per cycle while in_stall_o is low; a request is held in the
// input register, then its byte is scanned and, on end of body, the verdict
// is loaded into the result register.
// reset clears the lexer, the window and both flags.
// only an end-of-body request waits on a stalled result register.
`default_nettype none
module source_keyword_loop_io_scanner import skl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] char_code_i,
  input  wire logic       has_char_i,
  input  wire logic       end_of_body_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            loop_found_o,
  output logic            io_found_o,
  output logic            jittable_o
);

  logic       s1_valid_q, s1_valid_d;
  logic [7:0] char_q;
  logic       has_q, end_q;
  logic       out_valid_q, out_valid_d;
  logic       loop_out_q, io_out_q, jit_out_q;
  logic       loop_q, loop_d, io_q, io_d;
  logic       accept, s1_adv, out_free, load, step, as_code, loop_hit, io_hit;
  win_t       win;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!end_q || out_free);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept     = in_valid_i && !in_stall_o;
  assign step       = s1_adv && has_q;
  assign load       = s1_adv && end_q;

  skl_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .clr_i     (load),
    .char_i    (char_q),
    .as_code_o (as_code),
    .win_o     (win)
  );

  skl_match u_match (
    .step_i     (step),
    .char_i     (char_q),
    .as_code_i  (as_code),
    .win_i      (win),
    .loop_hit_o (loop_hit),
    .io_hit_o   (io_hit)
  );

  always_comb begin
    loop_d = loop_q || loop_hit;
    io_d   = io_q || io_hit;
    s1_valid_d = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = load ? 1'b1 : (out_valid_q && !out_stall_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      loop_q      <= 1'b0;
      io_q        <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      loop_q      <= load ? 1'b0 : loop_d;
      io_q        <= load ? 1'b0 : io_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_code_i;
      has_q  <= has_char_i;
      end_q  <= end_of_body_i;
    end
    if (load) begin
      loop_out_q <= loop_d;
      io_out_q   <= io_d;
      jit_out_q  <= loop_d && !io_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign loop_found_o = loop_out_q;
  assign io_found_o   = io_out_q;
  assign jittable_o   = jit_out_q;

`include "source_keyword_loop_io_scanner_macros.svh"

  `SKL_ASSERT_IMPL(a_verdict, out_valid_o && jittable_o, loop_found_o && !io_found_o)
  `SKL_ASSERT_IMPL(a_plain_no_stall, s1_valid_q && !end_q, !in_stall_o)
  `SKL_ASSERT_IMPL(a_end_blocked, s1_valid_q && end_q && out_valid_o && out_stall_i, in_stall_o)
  `SKL_ASSERT_NEXT(a_flags_clear, load, !loop_q && !io_q && out_valid_o)

endmodule
`default_nettype wire
